>>> rtl/core/stpb_pkg.sv
// Shared types and constants for the sharpen, threshold and bi-level pack block.
`timescale 1ns / 1ps
`default_nettype none
package stpb_pkg;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_DRAIN = 1'b1
   } op_type;

   localparam logic [1:0] CSR_IMAGE_WIDTH     = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT    = 2'd1;
   localparam logic [1:0] CSR_THRESHOLD_LEVEL = 2'd2;

   localparam logic [11:0] RESET_IMAGE_WIDTH     = 12'd2048;
   localparam logic [15:0] RESET_IMAGE_HEIGHT    = 16'd1;
   localparam logic [7:0]  RESET_THRESHOLD_LEVEL = 8'd127;

   localparam int WIN_ROWS  = 5;
   localparam int CMD_DEPTH = 4;
   localparam int OUT_DEPTH = 8;

   // Q8 kernel weights by squared distance from the center tap.
   localparam logic signed [11:0] W_D0 = 12'sd1280;
   localparam logic signed [11:0] W_D1 = -12'sd138;
   localparam logic signed [11:0] W_D2 = -12'sd74;
   localparam logic signed [11:0] W_D4 = -12'sd22;
   localparam logic signed [11:0] W_D5 = -12'sd12;
   localparam logic signed [11:0] W_D8 = -12'sd2;

   typedef struct packed {
      logic [7:0] sample;
      logic       wr_en;
      logic [2:0] rm;
      logic       emit;
      logic       border;
      logic       row_end;
      logic       frame_end;
   } cmd_type;

   typedef struct packed {
      logic [7:0] packed_bits;
      logic       row_end;
      logic       frame_end;
   } out_type;

   // Line store bank that holds window row j (0 is the top row) when rm is the
   // newest row modulo five.
   function automatic logic [2:0] row_bank(input logic [2:0] rm, input logic [2:0] j);
      logic [3:0] sum;
      sum = {1'b0, rm} + {1'b0, j} + 4'd1;
      if (sum >= 4'd5) begin
         sum = sum - 4'd5;
      end
      return sum[2:0];
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/sharpen_threshold_pack_bilevel.sv
// Top level of the 5x5 sharpen, threshold and bi-level byte packer.
//
//  channel  ports                                  direction  transaction
//  req      req_valid/req_stall, opcode, pixel     in         one pixel or drain item
//  rsp      rsp_valid/rsp_stall, bits, row/frame   out        one packed byte
//  csr      csr_wr_en, csr_index, csr_wr_data      in         one register write
//
// One input transaction per clock cycle is sustained while req_stall is low; the line store
// is five RAM banks, all read at the same column for each transaction, and only the bank of
// the newest row is written. A byte passes the command queue, RAM read, window, tap sum and
// bit registers and the output queue; output pixels lag the input by 2*width+2 positions,
// pushed out by drains. Reset is synchronous; the line store is not cleared and needs no clearing pass.
// Output stalls are absorbed by an eight entry output queue and a four entry
// command queue before req_stall rises.
`timescale 1ns / 1ps
`default_nettype none
module sharpen_threshold_pack_bilevel #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [7:0]  req_gray_pixel,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_packed_bits,
   output logic        rsp_row_end,
   output logic        rsp_frame_end,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wr_data
);
   import stpb_pkg::*;

   logic                         q_valid;
   logic                         q_pop;
   cmd_type                      q_cmd;
   logic [$clog2(MAX_WIDTH)-1:0] q_col;
   logic [7:0]                   threshold;
   logic                         restart;

   stpb_front #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_gray_pixel(req_gray_pixel),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .q_valid       (q_valid),
      .q_cmd         (q_cmd),
      .q_col         (q_col),
      .q_pop         (q_pop),
      .threshold     (threshold),
      .restart       (restart)
   );

   stpb_back #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_cmd          (q_cmd),
      .q_col          (q_col),
      .q_pop          (q_pop),
      .threshold      (threshold),
      .restart        (restart),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_packed_bits(rsp_packed_bits),
      .rsp_row_end    (rsp_row_end),
      .rsp_frame_end  (rsp_frame_end)
   );

endmodule
`default_nettype wire

>>> rtl/core/stpb_ram.sv
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module stpb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> rtl/core/stpb_front.sv
// Front end: registers, input accept, frame position tracking and command queue.
`timescale 1ns / 1ps
`default_nettype none
module stpb_front #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_opcode,
   input  logic [7:0]                   req_gray_pixel,
   input  logic                         csr_wr_en,
   input  logic [1:0]                   csr_index,
   input  logic [15:0]                  csr_wr_data,
   output logic                         q_valid,
   output stpb_pkg::cmd_type            q_cmd,
   output logic [$clog2(MAX_WIDTH)-1:0] q_col,
   input  logic                         q_pop,
   output logic [7:0]                   threshold,
   output logic                         restart
);
   import stpb_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int AW = $clog2(MAX_WIDTH);
   localparam int QW = $clog2(CMD_DEPTH);

   logic [11:0] width_ff;
   logic [15:0] height_ff;
   logic [7:0]  thr_ff;

   logic [CW-1:0] in_col_ff, in_col_in;
   logic [16:0]   in_row_ff, in_row_in;
   logic [2:0]    rm_ff, rm_in;
   logic [CW+1:0] lag_ff, lag_in;
   logic [CW-1:0] out_col_ff, out_col_in;
   logic [15:0]   out_row_ff, out_row_in;

   cmd_type       qc_ff [CMD_DEPTH];
   logic [AW-1:0] qa_ff [CMD_DEPTH];
   logic [QW-1:0] wp_ff, rp_ff;
   logic [QW:0]   cnt_ff;

   logic [31:0]   w_raw;
   logic [CW-1:0] eff_w;
   logic [15:0]   eff_h;
   logic [CW+1:0] lag_target;
   logic          fresh, accept, take, emit, in_last_col;
   logic          out_row_end, out_last_row, border, frame_end, full;
   cmd_type       new_cmd;

   assign restart = csr_wr_en && (csr_index == CSR_IMAGE_WIDTH ||
                    csr_index == CSR_IMAGE_HEIGHT || csr_index == CSR_THRESHOLD_LEVEL);
   assign threshold = thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_IMAGE_WIDTH;
         height_ff <= RESET_IMAGE_HEIGHT;
         thr_ff    <= RESET_THRESHOLD_LEVEL;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:     width_ff  <= csr_wr_data[11:0];
            CSR_IMAGE_HEIGHT:    height_ff <= csr_wr_data;
            CSR_THRESHOLD_LEVEL: thr_ff    <= csr_wr_data[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      w_raw = {20'd0, width_ff};
      if (w_raw == 32'd0) begin
         w_raw = 32'd1;
      end else if (w_raw > 32'(MAX_WIDTH)) begin
         w_raw = 32'(MAX_WIDTH);
      end
      eff_w = w_raw[CW-1:0];
      eff_h = (height_ff == 16'd0) ? 16'd1 : height_ff;
   end

   assign lag_target   = {1'b0, eff_w, 1'b0} + (CW+2)'(2);
   assign fresh        = (in_row_ff == 17'd0) && (in_col_ff == '0);
   assign full         = (cnt_ff == (QW+1)'(CMD_DEPTH));
   assign req_stall    = full;
   assign accept       = req_valid && !req_stall;
   assign take         = accept && !(op_type'(req_opcode) == OP_DRAIN && fresh);
   assign emit         = (lag_ff == lag_target);
   assign in_last_col  = ({1'b0, in_col_ff} + (CW+1)'(1)) == {1'b0, eff_w};
   assign out_row_end  = ({1'b0, out_col_ff} + (CW+1)'(1)) == {1'b0, eff_w};
   assign out_last_row = ({1'b0, out_row_ff} + 17'd1) == {1'b0, eff_h};
   assign border = (out_row_ff < 16'd2) || (({1'b0, out_row_ff} + 17'd2) >= {1'b0, eff_h}) ||
                   (out_col_ff < CW'(2)) ||
                   (({1'b0, out_col_ff} + (CW+1)'(2)) >= {1'b0, eff_w});
   assign frame_end = emit && out_row_end && out_last_row;

   always_comb begin
      new_cmd.sample    = (op_type'(req_opcode) == OP_DRAIN) ? 8'd0 : req_gray_pixel;
      new_cmd.wr_en     = in_row_ff < {1'b0, eff_h};
      new_cmd.rm        = rm_ff;
      new_cmd.emit      = emit;
      new_cmd.border    = border;
      new_cmd.row_end   = out_row_end;
      new_cmd.frame_end = frame_end;
   end

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      rm_in      = rm_ff;
      lag_in     = lag_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (restart) begin
         in_col_in  = '0;
         in_row_in  = '0;
         rm_in      = '0;
         lag_in     = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (take) begin
         if (in_last_col) begin
            in_col_in = '0;
            in_row_in = in_row_ff + 17'd1;
            rm_in     = (rm_ff == 3'd4) ? 3'd0 : rm_ff + 3'd1;
         end else begin
            in_col_in = in_col_ff + CW'(1);
         end
         if (emit) begin
            if (out_row_end) begin
               out_col_in = '0;
               out_row_in = out_row_ff + 16'd1;
            end else begin
               out_col_in = out_col_ff + CW'(1);
            end
         end else begin
            lag_in = lag_ff + (CW+2)'(1);
         end
         // The frame's last output pixel starts a new frame at the next item.
         if (frame_end) begin
            in_col_in  = '0;
            in_row_in  = '0;
            rm_in      = '0;
            lag_in     = '0;
            out_col_in = '0;
            out_row_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         rm_ff      <= '0;
         lag_ff     <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         rm_ff      <= rm_in;
         lag_ff     <= lag_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         qc_ff[wp_ff] <= new_cmd;
         qa_ff[wp_ff] <= in_col_ff[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (take) begin
            wp_ff <= wp_ff + QW'(1);
         end
         if (q_pop) begin
            rp_ff <= rp_ff + QW'(1);
         end
         cnt_ff <= cnt_ff + (QW+1)'(take) - (QW+1)'(q_pop);
      end
   end

   assign q_valid = (cnt_ff != '0);
   assign q_cmd   = qc_ff[rp_ff];
   assign q_col   = qa_ff[rp_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      take |-> !full) else $error("command queue written while full");
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("command queue popped while empty");
   a_emit_in_lag: assert property (@(posedge clock) disable iff (reset)
      !emit |-> lag_ff < lag_target) else $error("lag counter overran its target");

endmodule
`default_nettype wire

>>> rtl/core/stpb_back.sv
// Back end: line store, 5x5 window, sharpening filter, threshold, bit packer, output queue.
`timescale 1ns / 1ps
`default_nettype none
module stpb_back #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  stpb_pkg::cmd_type            q_cmd,
   input  logic [$clog2(MAX_WIDTH)-1:0] q_col,
   output logic                         q_pop,
   input  logic [7:0]                   threshold,
   input  logic                         restart,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [7:0]                   rsp_packed_bits,
   output logic                         rsp_row_end,
   output logic                         rsp_frame_end
);
   import stpb_pkg::*;

   localparam int OW = $clog2(OUT_DEPTH);

   logic [7:0] rd_data [WIN_ROWS];
   logic [7:0] bank_data [WIN_ROWS];
   logic [7:0] new_col [WIN_ROWS];
   logic [7:0] win_ff [WIN_ROWS][WIN_ROWS];

   logic    s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff;
   cmd_type s1_cmd_ff, s2_cmd_ff, s3_cmd_ff, s4_cmd_ff;

   logic [9:0]  g1_in, g2_in, g4_in, g8_in;
   logic [10:0] g5_in;
   logic [9:0]  g1_ff, g2_ff, g4_ff, g8_ff;
   logic [10:0] g5_ff;
   logic [7:0]  center_ff;

   logic signed [21:0] sum;
   logic [7:0] filt;
   logic       bit_in, s4_bit_ff;

   logic [7:0] acc_ff, acc_in;
   logic [2:0] pcnt_ff;
   logic [3:0] cnt_n;
   logic       push, pop;
   out_type    push_data;

   out_type     oq_ff [OUT_DEPTH];
   logic [OW-1:0] owp_ff, orp_ff;
   logic [OW:0]   ocnt_ff;
   logic [OW+1:0] inflight;

   // Each transaction in flight in the filter may still produce a byte, so a
   // command is taken only when the output queue has room for all of them.
   assign inflight = (OW+2)'(s1_v_ff) + (OW+2)'(s2_v_ff) + (OW+2)'(s3_v_ff) +
                     (OW+2)'(s4_v_ff) + {1'b0, ocnt_ff};
   assign q_pop = q_valid && (inflight < (OW+2)'(OUT_DEPTH));

   for (genvar b = 0; b < WIN_ROWS; b++) begin : g_bank
      stpb_ram #(
         .WIDTH(8),
         .DEPTH(MAX_WIDTH)
      ) u_line (
         .clock  (clock),
         .wr_en  (q_pop && q_cmd.wr_en && (q_cmd.rm == 3'(b))),
         .wr_addr(q_col),
         .wr_data(q_cmd.sample),
         .rd_en  (q_pop),
         .rd_addr(q_col),
         .rd_data(rd_data[b])
      );
   end

   // The read gives the pre-write value, so this transaction's written sample is forwarded.
   always_comb begin
      for (int b = 0; b < WIN_ROWS; b++) begin
         bank_data[b] = (s1_cmd_ff.wr_en && s1_cmd_ff.rm == 3'(b)) ? s1_cmd_ff.sample
                                                                    : rd_data[b];
      end
      for (int j = 0; j < WIN_ROWS; j++) begin
         new_col[j] = bank_data[row_bank(s1_cmd_ff.rm, 3'(j))];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_v_ff) begin
         for (int c = 0; c < WIN_ROWS - 1; c++) begin
            for (int r = 0; r < WIN_ROWS; r++) begin
               win_ff[c][r] <= win_ff[c+1][r];
            end
         end
         for (int r = 0; r < WIN_ROWS; r++) begin
            win_ff[WIN_ROWS-1][r] <= new_col[r];
         end
      end
   end

   // Window taps grouped by squared distance; win_ff is indexed [column][row].
   always_comb begin
      g1_in = 10'(win_ff[2][1]) + 10'(win_ff[2][3]) + 10'(win_ff[1][2]) + 10'(win_ff[3][2]);
      g2_in = 10'(win_ff[1][1]) + 10'(win_ff[1][3]) + 10'(win_ff[3][1]) + 10'(win_ff[3][3]);
      g4_in = 10'(win_ff[2][0]) + 10'(win_ff[2][4]) + 10'(win_ff[0][2]) + 10'(win_ff[4][2]);
      g8_in = 10'(win_ff[0][0]) + 10'(win_ff[0][4]) + 10'(win_ff[4][0]) + 10'(win_ff[4][4]);
      g5_in = 11'(win_ff[1][0]) + 11'(win_ff[3][0]) + 11'(win_ff[1][4]) + 11'(win_ff[3][4]) +
              11'(win_ff[0][1]) + 11'(win_ff[0][3]) + 11'(win_ff[4][1]) + 11'(win_ff[4][3]);
   end

   always_ff @(posedge clock) begin
      if (s2_v_ff) begin
         g1_ff     <= g1_in;
         g2_ff     <= g2_in;
         g4_ff     <= g4_in;
         g5_ff     <= g5_in;
         g8_ff     <= g8_in;
         center_ff <= win_ff[2][2];
      end
   end

   always_comb begin
      sum = $signed({14'd0, center_ff}) * W_D0 + $signed({12'd0, g1_ff}) * W_D1 +
            $signed({12'd0, g2_ff}) * W_D2 + $signed({12'd0, g4_ff}) * W_D4 +
            $signed({11'd0, g5_ff}) * W_D5 + $signed({12'd0, g8_ff}) * W_D8;
      if (sum[21]) begin
         filt = 8'd0;
      end else if (sum[20:16] != 5'd0) begin
         filt = 8'd255;
      end else begin
         filt = sum[15:8];
      end
      if (s3_cmd_ff.border) begin
         filt = center_ff;
      end
      bit_in = filt > threshold;
   end

   always_ff @(posedge clock) begin
      if (s3_v_ff) begin
         s4_bit_ff <= bit_in;
      end
      if (q_pop) begin
         s1_cmd_ff <= q_cmd;
      end
      if (s1_v_ff) begin
         s2_cmd_ff <= s1_cmd_ff;
      end
      if (s2_v_ff) begin
         s3_cmd_ff <= s2_cmd_ff;
      end
      if (s3_v_ff) begin
         s4_cmd_ff <= s3_cmd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= q_pop;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
      end
   end

   always_comb begin
      cnt_n  = {1'b0, pcnt_ff} + 4'd1;
      acc_in = {acc_ff[6:0], s4_bit_ff};
      push   = s4_v_ff && s4_cmd_ff.emit && (cnt_n == 4'd8 || s4_cmd_ff.row_end);
      push_data.packed_bits = acc_in << (4'd8 - cnt_n);
      push_data.row_end     = s4_cmd_ff.row_end;
      push_data.frame_end   = s4_cmd_ff.frame_end;
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         acc_ff  <= '0;
         pcnt_ff <= '0;
      end else if (s4_v_ff && s4_cmd_ff.emit) begin
         if (push) begin
            acc_ff  <= '0;
            pcnt_ff <= '0;
         end else begin
            acc_ff  <= acc_in;
            pcnt_ff <= cnt_n[2:0];
         end
      end
   end

   assign pop = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (push) begin
         oq_ff[owp_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owp_ff  <= '0;
         orp_ff  <= '0;
         ocnt_ff <= '0;
      end else begin
         if (push) begin
            owp_ff <= owp_ff + OW'(1);
         end
         if (pop) begin
            orp_ff <= orp_ff + OW'(1);
         end
         ocnt_ff <= ocnt_ff + (OW+1)'(push) - (OW+1)'(pop);
      end
   end

   assign rsp_valid       = (ocnt_ff != '0);
   assign rsp_packed_bits = oq_ff[orp_ff].packed_bits;
   assign rsp_row_end     = oq_ff[orp_ff].row_end;
   assign rsp_frame_end   = oq_ff[orp_ff].frame_end;

   a_credit: assert property (@(posedge clock) disable iff (reset)
      inflight <= (OW+2)'(OUT_DEPTH)) else $error("output credit exceeded");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> (ocnt_ff < (OW+1)'(OUT_DEPTH)) || pop) else $error("output queue overflow");
   a_frame_row: assert property (@(posedge clock) disable iff (reset)
      push && push_data.frame_end |-> push_data.row_end)
      else $error("frame end without row end");

endmodule
`default_nettype wire

>>> tb/sv/sharpen_threshold_pack_bilevel_tb.sv
// Self-checking testbench for the sharpen, threshold and bi-level pack block.
`timescale 1ns / 1ps
module sharpen_threshold_pack_bilevel_tb;
   import stpb_pkg::*;

   localparam int LINE_W      = 2048;
   localparam int CYCLE_LIMIT = 1500000;

   class bilevel_scoreboard;
      logic [7:0]  line_mem [WIN_ROWS * LINE_W];
      logic [11:0] width_reg;
      logic [15:0] height_reg;
      logic [7:0]  thresh_reg;
      int          in_pos;
      int          out_row;
      int          out_col;
      logic [7:0]  acc;
      int          acc_count;
      out_type     pending_bytes [$];
      int          errors;

      function new();
         foreach (line_mem[i]) line_mem[i] = 8'd0;
         width_reg  = RESET_IMAGE_WIDTH;
         height_reg = RESET_IMAGE_HEIGHT;
         thresh_reg = RESET_THRESHOLD_LEVEL;
         errors     = 0;
         restart_frame();
      endfunction

      function void restart_frame();
         in_pos    = 0;
         out_row   = 0;
         out_col   = 0;
         acc       = 8'd0;
         acc_count = 0;
      endfunction

      function int eff_w();
         if (width_reg == 0) return 1;
         if (width_reg > LINE_W) return LINE_W;
         return width_reg;
      endfunction

      function int eff_h();
         return (height_reg == 0) ? 1 : height_reg;
      endfunction

      function void write_reg(logic [1:0] idx, logic [15:0] data);
         case (idx)
            CSR_IMAGE_WIDTH: width_reg = data[11:0];
            CSR_IMAGE_HEIGHT: height_reg = data;
            CSR_THRESHOLD_LEVEL: thresh_reg = data[7:0];
            default: return;
         endcase
         restart_frame();
      endfunction

      function int pix(int r, int c);
         return line_mem[(r % WIN_ROWS) * LINE_W + c];
      endfunction

      function int sharpened(int y, int x, int w, int h);
         int sum;
         int d2;
         int wt;
         if (y < 2 || y + 2 >= h || x < 2 || x + 2 >= w) return pix(y, x);
         sum = 0;
         for (int dy = -2; dy <= 2; dy++) begin
            for (int dx = -2; dx <= 2; dx++) begin
               d2 = dx * dx + dy * dy;
               case (d2)
                  0: wt = W_D0;
                  1: wt = W_D1;
                  2: wt = W_D2;
                  4: wt = W_D4;
                  5: wt = W_D5;
                  8: wt = W_D8;
                  default: wt = 0;
               endcase
               sum += wt * pix(y + dy, x + dx);
            end
         end
         if (sum < 0) return 0;
         sum = sum / 256;
         return (sum > 255) ? 255 : sum;
      endfunction

      function void note_input(op_type op, logic [7:0] px);
         int w;
         int h;
         int p;
         logic bit_v;
         logic re;
         logic fe;
         out_type ob;
         w = eff_w();
         h = eff_h();
         p = in_pos;
         if (op == OP_DRAIN && p == 0) return;
         if (p < w * h) line_mem[((p / w) % WIN_ROWS) * LINE_W + (p % w)] =
            (op == OP_DRAIN) ? 8'd0 : px;
         in_pos = p + 1;
         if (p < 2 * w + 2) return;
         bit_v = (sharpened(out_row, out_col, w, h) > thresh_reg);
         acc = {acc[6:0], bit_v};
         acc_count++;
         re = (out_col + 1 >= w);
         fe = re && (out_row + 1 >= h);
         if (re) begin
            out_col = 0;
            out_row++;
         end else begin
            out_col++;
         end
         if (acc_count < 8 && !re) return;
         ob.packed_bits = acc << (8 - acc_count);
         ob.row_end     = re;
         ob.frame_end   = fe;
         pending_bytes.push_back(ob);
         acc       = 8'd0;
         acc_count = 0;
         if (fe) restart_frame();
      endfunction

      function void check_result(logic [7:0] bits, logic re, logic fe);
         out_type ob;
         if (pending_bytes.size() == 0) begin
            $error("unexpected result transaction: packed_bits %0h", bits);
            errors++;
            return;
         end
         ob = pending_bytes.pop_front();
         if (bits !== ob.packed_bits) begin
            $error("packed_bits expected %0h actual %0h", ob.packed_bits, bits);
            errors++;
         end
         if (re !== ob.row_end) begin
            $error("row_end expected %0b actual %0b", ob.row_end, re);
            errors++;
         end
         if (fe !== ob.frame_end) begin
            $error("frame_end expected %0b actual %0b", ob.frame_end, fe);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_opcode;
   logic [7:0]  req_gray_pixel;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_packed_bits;
   logic        rsp_row_end;
   logic        rsp_frame_end;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [15:0] csr_wr_data;

   bilevel_scoreboard sb;
   bit quiet;
   int cycles;
   int stall_left;
   int random_items;

   sharpen_threshold_pack_bilevel u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_opcode(req_opcode), .req_gray_pixel(req_gray_pixel),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_packed_bits(rsp_packed_bits), .rsp_row_end(rsp_row_end),
      .rsp_frame_end(rsp_frame_end),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Receiver back-pressure comes in random bursts.
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= (stall_left > 1);
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(1, 14);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_packed_bits, rsp_row_end, rsp_frame_end);
   end

   task automatic send_item(op_type op, logic [7:0] px);
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_gray_pixel <= px;
      do @(posedge clock); while (req_stall);
      sb.note_input(op, px);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending_bytes.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] data);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.write_reg(idx, data);
   endtask

   // One frame: the samples, each a drain with noise_pct percent chance, then the tail that flushes the lag.
   task automatic run_frame(int noise_pct);
      int w;
      int h;
      op_type op;
      w = sb.eff_w();
      h = sb.eff_h();
      for (int i = 0; i < w * h + 2 * w + 2; i++) begin
         if (i >= w * h) op = ($urandom_range(0, 1) == 0) ? OP_DRAIN : OP_PIXEL;
         else op = ($urandom_range(0, 99) < noise_pct) ? OP_DRAIN : OP_PIXEL;
         send_item(op, 8'($urandom_range(0, 255)));
         random_items++;
      end
   endtask

   initial begin
      sb             = new();
      clock          = 1'b0;
      reset          = 1'b1;
      quiet          = 1'b0;
      cycles         = 0;
      random_items   = 0;
      req_valid      = 1'b0;
      req_opcode     = OP_PIXEL;
      req_gray_pixel = 8'd0;
      rsp_stall      = 1'b0;
      csr_wr_en      = 1'b0;
      csr_index      = CSR_IMAGE_WIDTH;
      csr_wr_data    = 16'd0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Drains with no frame in progress are ignored.
      send_item(OP_DRAIN, 8'hff);
      send_item(OP_DRAIN, 8'h00);
      // Reset setting: a full-width row is started and then abandoned by a register write.
      for (int i = 0; i < 40; i++) send_item(OP_PIXEL, 8'($urandom_range(0, 255)));
      // Zero width and height act as one.
      write_csr(CSR_IMAGE_WIDTH, 16'd0);
      write_csr(CSR_IMAGE_HEIGHT, 16'd0);
      run_frame(0);
      // Smallest frame with one filtered pixel, extreme samples and thresholds.
      write_csr(CSR_IMAGE_WIDTH, 16'd5);
      write_csr(CSR_IMAGE_HEIGHT, 16'd5);
      for (int t = 0; t < 2; t++) begin
         write_csr(CSR_THRESHOLD_LEVEL, t ? 16'd255 : 16'd0);
         for (int i = 0; i < 37; i++)
            send_item(OP_PIXEL, (i == 12) ? 8'hff : ((i % 2) ? 8'h00 : 8'hff));
      end
      write_csr(CSR_THRESHOLD_LEVEL, 16'hff7f);
      for (int i = 0; i < 37; i++) send_item(OP_PIXEL, (i == 12) ? 8'h00 : 8'hff);
      // Width beyond the line store acts as the maximum; the frame is abandoned early.
      write_csr(CSR_IMAGE_WIDTH, 16'hffff);
      write_csr(CSR_IMAGE_HEIGHT, 16'd3);
      for (int i = 0; i < 40; i++) send_item(OP_PIXEL, 8'($urandom_range(0, 255)));
      // Tallest frame is started and then abandoned by a register write.
      write_csr(CSR_IMAGE_WIDTH, 16'd1);
      write_csr(CSR_IMAGE_HEIGHT, 16'hffff);
      for (int i = 0; i < 30; i++) send_item(OP_PIXEL, 8'($urandom_range(0, 255)));
      wait_drained();

      random_items = 0;
      while (random_items < 1700) begin
         if (random_items > 1400) quiet = 1'b1;
         case ($urandom_range(0, 3))
            0: write_csr(CSR_IMAGE_WIDTH, 16'($urandom_range(1, 24)));
            1: write_csr(CSR_IMAGE_HEIGHT, 16'($urandom_range(1, 7)));
            2: write_csr(CSR_THRESHOLD_LEVEL, 16'($urandom_range(0, 1) ?
                         $urandom_range(0, 255) : ($urandom_range(0, 1) ? 255 : 0)));
            default: ;
         endcase
         if ($urandom_range(0, 9) == 0) begin
            // Broken frame: partial input, then a restart by register write.
            for (int i = $urandom_range(1, 40); i > 0; i--) begin
               send_item(op_type'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
               random_items++;
            end
            write_csr(CSR_THRESHOLD_LEVEL, 16'($urandom_range(0, 255)));
         end else begin
            if ($urandom_range(0, 4) == 0) send_item(OP_DRAIN, 8'($urandom_range(0, 255)));
            run_frame($urandom_range(0, 15));
         end
      end

      wait_drained();
      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
